### src/crb_pkg.sv
package crb_pkg;

	// Store and bitmap sizes.
	localparam int STORE_BYTES = 4096;
	localparam int MAX_CHUNKS  = 64;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	// Width for offset plus length, limits and message ends.
	localparam int END_W = 17;

	// Item modes.
	typedef enum logic [1:0] {
		MODE_DATA  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_NOT_READY = 2'd0,
		ST_READY     = 2'd1,
		ST_INVALID   = 2'd2,
		ST_READ      = 2'd3
	} status_t;

	// Write request into the message store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	// One result on its way to the output register.
	typedef struct packed {
		status_t          status;
		logic [END_W-1:0] total;
		logic [6:0]       count;
		logic             rd_ok;
	} res_t;

endpackage

### src/crb_store.sv
module crb_store (
	input  logic                         clk,
	input  crb_pkg::wr_req_t             wr,
	input  logic                         rd_en,
	input  logic [crb_pkg::ADDR_W-1:0]   rd_addr,
	output logic [7:0]                   rd_data
);

	logic [7:0] mem [crb_pkg::STORE_BYTES];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/chunk_reassembly_bitmap.sv
// Chunk reassembly with a received bitmap.
// Input channel (in_valid/in_ready) carries one item per cycle: a chunk data
// byte (mode 0), a clear of the tracking state (mode 1) or a read of one stored
// byte (mode 2). Data bytes are written into a 4096 byte store at offset plus
// byte position; the first item of each chunk updates the bitmap and counts.
// Output channel (out_valid/out_ready) carries one item on the last byte of a
// chunk, on an invalid chunk index, and on every read.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes the
// buffer capacity; write it only while the block is idle.
// Throughput is one item per cycle while the receiver does not stall. An
// accepted item passes stage one, which covers the synchronous store read,
// then the output register. A stalled receiver holds the output register and
// then the stage before it; the input stalls only when both are full.
// Reset clears the bitmap, counts, chunk progress and pipeline, and sets the
// capacity to 4096. The store contents are undefined until written and are
// not cleared.
module chunk_reassembly_bitmap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [6:0]  chunk_id,
	input  logic [6:0]  chunk_count,
	input  logic [15:0] chunk_offset,
	input  logic [15:0] chunk_length,
	input  logic [7:0]  data_byte,
	input  logic [11:0] read_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [16:0] msg_size,
	output logic [6:0]  chunks_seen,
	output logic [7:0]  read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data
);

	localparam int EW = crb_pkg::END_W;
	localparam int NC = crb_pkg::MAX_CHUNKS;

	// Tracking state.
	logic [12:0]   capacity_q;
	logic [NC-1:0] bits_q;
	logic [6:0]    expected_q;
	logic [6:0]    count_q;
	logic [EW-1:0] end_q;
	logic [15:0]   pos_q;
	logic          writable_q;
	logic          dup_q;

	// Pipeline and output registers.
	logic          valid_s1;
	crb_pkg::res_t res_s1;
	logic          out_valid_q;
	crb_pkg::res_t out_q;
	logic [7:0]    rdata_q;

	logic          accept;
	logic          s1_go;
	logic          is_data;
	logic          is_read;
	logic          idx_ok;
	logic          first;
	logic          last;
	logic [EW-1:0] limit;
	logic [EW-1:0] chunk_end;
	logic [EW-1:0] waddr;
	logic [NC-1:0] mask;
	logic          dup_new;
	logic          wr_new;
	logic          eff_dup;
	logic          eff_wr;
	logic          new_chunk;
	logic [6:0]    expected_n;
	logic [6:0]    count_n;
	logic [EW-1:0] end_n;
	logic          res_v;
	crb_pkg::res_t res_n;
	crb_pkg::wr_req_t wr;
	logic [7:0]    store_rdata;

	// Handshakes.
	assign s1_go     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_go;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Decode and chunk bookkeeping for the accepted item.
	always_comb begin
		is_data   = mode == crb_pkg::MODE_DATA;
		is_read   = mode == crb_pkg::MODE_READ;
		idx_ok    = {1'b0, chunk_id} < 8'(NC);
		first     = pos_q == 16'd0;
		last      = (EW'(pos_q) + EW'(1)) >= EW'(chunk_length);
		limit     = (EW'(capacity_q) < EW'(crb_pkg::STORE_BYTES)) ?
			EW'(capacity_q) : EW'(crb_pkg::STORE_BYTES);
		chunk_end = EW'(chunk_offset) + EW'(chunk_length);
		waddr     = EW'(chunk_offset) + EW'(pos_q);
		mask      = '0;
		mask[0]   = 1'b1;
		mask      = mask << chunk_id;
		dup_new   = |(bits_q & mask);
		wr_new    = chunk_end <= limit;
		eff_dup   = first ? dup_new : dup_q;
		eff_wr    = first ? wr_new : writable_q;
		new_chunk = first && !dup_new;
		expected_n = (first && expected_q == 7'd0) ? chunk_count : expected_q;
		count_n   = (new_chunk && count_q < 7'd127) ? count_q + 7'd1 : count_q;
		end_n     = (new_chunk && chunk_end > end_q) ? chunk_end : end_q;
	end

	// Store write request for a data byte that lands inside the store.
	always_comb begin
		wr.en   = accept && is_data && idx_ok && chunk_length != 16'd0 &&
			eff_wr && !eff_dup && waddr < limit;
		wr.addr = waddr[crb_pkg::ADDR_W-1:0];
		wr.data = data_byte;
	end

	crb_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept && is_read),
		.rd_addr (read_address),
		.rd_data (store_rdata)
	);

	// Result of the accepted item, if it produces one.
	always_comb begin
		res_v        = 1'b0;
		res_n.status = crb_pkg::ST_NOT_READY;
		res_n.total  = end_q;
		res_n.count  = count_q;
		res_n.rd_ok  = EW'(read_address) < EW'(crb_pkg::STORE_BYTES);
		case (mode)
			crb_pkg::MODE_READ: begin
				res_v        = accept;
				res_n.status = crb_pkg::ST_READ;
			end
			crb_pkg::MODE_DATA: begin
				if (!idx_ok) begin
					res_v        = accept;
					res_n.status = crb_pkg::ST_INVALID;
				end else begin
					res_v        = accept && last;
					res_n.total  = end_n;
					res_n.count  = count_n;
					res_n.status = (count_n >= expected_n) ?
						crb_pkg::ST_READY : crb_pkg::ST_NOT_READY;
				end
			end
			default: begin
				res_v = 1'b0;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Tracking state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q     <= '0;
			expected_q <= '0;
			count_q    <= '0;
			end_q      <= '0;
			pos_q      <= '0;
			writable_q <= 1'b0;
			dup_q      <= 1'b0;
		end else if (accept) begin
			if (mode == crb_pkg::MODE_CLEAR) begin
				bits_q     <= '0;
				expected_q <= '0;
				count_q    <= '0;
				end_q      <= '0;
				pos_q      <= '0;
				writable_q <= 1'b0;
				dup_q      <= 1'b0;
			end else if (is_data && idx_ok) begin
				if (new_chunk) begin
					bits_q <= bits_q | mask;
				end
				expected_q <= expected_n;
				count_q    <= count_n;
				end_q      <= end_n;
				writable_q <= eff_wr;
				dup_q      <= eff_dup;
				pos_q      <= last ? 16'd0 : pos_q + 16'd1;
			end
		end
	end

	// Stage one waits for the store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q   <= res_s1;
			rdata_q <= (res_s1.status == crb_pkg::ST_READ && res_s1.rd_ok) ?
				store_rdata : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign msg_size    = out_q.total;
	assign chunks_seen = out_q.count;
	assign read_data   = rdata_q;

endmodule

### src/crb_checker.sv
module crb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [16:0] msg_size,
	input logic [6:0]  chunks_seen,
	input logic [7:0]  read_data,
	input logic        cfg_ready
);

	// A stalled item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(msg_size) && $stable(chunks_seen) && $stable(read_data))
		else $error("output item changed while stalled");

	// Only reads carry a data byte.
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != crb_pkg::ST_READ |-> read_data == 8'd0)
		else $error("read_data nonzero on a non-read item");

	// Distinct chunks never exceed the bitmap size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunks_seen <= 7'(crb_pkg::MAX_CHUNKS))
		else $error("chunks_seen beyond bitmap size");

	// A read item always passes stage one and the output register when nothing stalls.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == crb_pkg::MODE_READ && !out_valid ##1
		out_ready |=> out_valid && status == crb_pkg::ST_READ)
		else $error("read item not delivered on time");

	// The configuration port never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg_ready low");

endmodule

bind chunk_reassembly_bitmap crb_checker u_crb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.msg_size    (msg_size),
	.chunks_seen (chunks_seen),
	.read_data   (read_data),
	.cfg_ready   (cfg_ready)
);

### sim/chunk_reassembly_checker.sv
`timescale 1ns / 1ps

module chunk_reassembly_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      mode,
	input  logic [6:0]                      chunk_id,
	input  logic [6:0]                      chunk_count,
	input  logic [15:0]                     chunk_offset,
	input  logic [15:0]                     chunk_length,
	input  logic [7:0]                      data_byte,
	input  logic [11:0]                     read_address,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [1:0]                      status,
	input  logic [16:0]                     msg_size,
	input  logic [6:0]                      chunks_seen,
	input  logic [7:0]                      read_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [12:0]                     cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              results_checked,
	output logic [crb_pkg::STORE_BYTES-1:0] stored
);

	// One predicted report of the block.
	typedef struct {
		crb_pkg::status_t st;
		logic [16:0]      total;
		logic [6:0]       count;
		logic [7:0]       data;
	} report_t;

	report_t awaited_reports[$];

	// Shadow copy of the reassembly state.
	logic [7:0]  store_img [crb_pkg::STORE_BYTES];
	logic [63:0] seen_bits;
	logic [6:0]  want_count;
	logic [6:0]  have_count;
	logic [16:0] far_end;
	logic [15:0] pos;
	logic        writable;
	logic        dup;
	logic [12:0] capacity;

	int mismatches;
	int reports_seen;

	assign fail_count      = mismatches;
	assign results_checked = reports_seen;

	task automatic clear_progress();
		seen_bits  = '0;
		want_count = '0;
		have_count = '0;
		far_end    = '0;
		pos        = '0;
		writable   = 1'b0;
		dup        = 1'b0;
	endtask

	// Apply one accepted item to the shadow state and queue its report, if any.
	task automatic absorb_item(input logic [1:0] m, input logic [6:0] idx,
			input logic [6:0] tot, input logic [15:0] off, input logic [15:0] len,
			input logic [7:0] b, input logic [11:0] ra);
		int          limit;
		int          stop;
		int          addr;
		logic [63:0] bit_mask;
		limit = (int'(capacity) < crb_pkg::STORE_BYTES) ? int'(capacity) :
			crb_pkg::STORE_BYTES;
		case (m)
			crb_pkg::MODE_CLEAR: begin
				clear_progress();
			end
			crb_pkg::MODE_READ: begin
				awaited_reports.push_back('{crb_pkg::ST_READ, far_end, have_count,
					store_img[ra]});
			end
			crb_pkg::MODE_DATA: begin
				if (int'(idx) >= crb_pkg::MAX_CHUNKS) begin
					awaited_reports.push_back('{crb_pkg::ST_INVALID, far_end, have_count,
						8'd0});
				end else begin
					// The first item of a chunk does its bookkeeping.
					if (pos == 0) begin
						bit_mask = 64'd1 << idx[5:0];
						stop = int'(off) + int'(len);
						if (want_count == 0)
							want_count = tot;
						dup = (seen_bits & bit_mask) != 0;
						writable = stop <= limit;
						if (!dup) begin
							seen_bits = seen_bits | bit_mask;
							if (have_count < 7'd127)
								have_count = have_count + 7'd1;
							if (stop > int'(far_end))
								far_end = stop[16:0];
						end
					end
					// Store the byte when the chunk is fresh and fits.
					if (len != 0 && writable && !dup) begin
						addr = int'(off) + int'(pos);
						if (addr < limit) begin
							store_img[addr] = b;
							stored[addr] <= 1'b1;
						end
					end
					// The final byte, or a zero-length chunk, reports readiness.
					if (int'(pos) + 1 >= int'(len)) begin
						pos = '0;
						awaited_reports.push_back('{(have_count >= want_count) ?
							crb_pkg::ST_READY : crb_pkg::ST_NOT_READY, far_end,
							have_count, 8'd0});
					end else begin
						pos = pos + 16'd1;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Compare results first, then fold in the item and register writes of this edge.
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			clear_progress();
			capacity = 13'd4096;
			awaited_reports.delete();
			mismatches = 0;
			reports_seen = 0;
			pending <= 0;
			stored <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: status %0d size %0d count %0d data %0h",
						$time, status, msg_size, chunks_seen, read_data);
				end else begin
					want = awaited_reports.pop_front();
					reports_seen++;
					if (status !== want.st) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					end
					if (msg_size !== want.total) begin
						mismatches++;
						$display("%0t: msg_size expected %0d actual %0d",
							$time, want.total, msg_size);
					end
					if (chunks_seen !== want.count) begin
						mismatches++;
						$display("%0t: chunks_seen expected %0d actual %0d",
							$time, want.count, chunks_seen);
					end
					if (read_data !== want.data) begin
						mismatches++;
						$display("%0t: read_data expected %0h actual %0h",
							$time, want.data, read_data);
					end
				end
			end
			if (in_valid && in_ready)
				absorb_item(mode, chunk_id, chunk_count, chunk_offset, chunk_length,
					data_byte, read_address);
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			pending <= awaited_reports.size();
		end
	end

endmodule

### sim/chunk_reassembly_bitmap_test.sv
`timescale 1ns / 1ps

module chunk_reassembly_bitmap_test;

	// Mode code that the block ignores.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [6:0]  chunk_id;
	logic [6:0]  chunk_count;
	logic [15:0] chunk_offset;
	logic [15:0] chunk_length;
	logic [7:0]  data_byte;
	logic [11:0] read_address;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [16:0] msg_size;
	logic [6:0]  chunks_seen;
	logic [7:0]  read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;

	int                              fail_count;
	int                              pending;
	int                              results_checked;
	logic [crb_pkg::STORE_BYTES-1:0] stored;

	int in_idle;
	int out_idle;
	int items_sent;
	int n_data;
	int n_clear;
	int n_read;
	int n_unused;
	int cap_writes;
	int cur_cap;

	chunk_reassembly_bitmap dut (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .chunk_id, .chunk_count,
		.chunk_offset, .chunk_length, .data_byte, .read_address, .out_valid, .out_ready,
		.status, .msg_size, .chunks_seen, .read_data, .cfg_valid, .cfg_ready,
		.cfg_data
	);

	chunk_reassembly_checker monitor_u (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .chunk_id, .chunk_count,
		.chunk_offset, .chunk_length, .data_byte, .read_address, .out_valid, .out_ready,
		.status, .msg_size, .chunks_seen, .read_data, .cfg_valid, .cfg_ready,
		.cfg_data, .fail_count, .pending, .results_checked, .stored
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random according to the current profile.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= out_idle);

	// Hard stop in case the block hangs.
	initial begin
		#5000000;
		$display("chunk_reassembly_bitmap regression: fail");
		$finish;
	end

	// Offer one item, with an optional gap first, and wait until it is taken.
	task automatic send_item(input logic [1:0] m, input int idx, input int tot,
			input int off, input int len, input int b, input int ra);
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		chunk_id     <= 7'(idx);
		chunk_count  <= 7'(tot);
		chunk_offset <= 16'(off);
		chunk_length <= 16'(len);
		data_byte    <= 8'(b);
		read_address <= 12'(ra);
		do @(posedge clk); while (!in_ready);
		items_sent++;
		case (m)
			crb_pkg::MODE_DATA:  n_data++;
			crb_pkg::MODE_CLEAR: n_clear++;
			crb_pkg::MODE_READ:  n_read++;
			default:             n_unused++;
		endcase
	endtask

	// Write the capacity once the block has drained.
	task automatic set_capacity(input int value);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= 13'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_cap = value;
		cap_writes++;
	endtask

	// Find a store address that has already been written.
	function automatic bit pick_stored(output int addr);
		int start;
		addr = 0;
		start = $urandom_range(crb_pkg::STORE_BYTES - 1);
		for (int k = 0; k < crb_pkg::STORE_BYTES; k++) begin
			if (stored[(start + k) % crb_pkg::STORE_BYTES]) begin
				addr = (start + k) % crb_pkg::STORE_BYTES;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic read_back();
		int ra;
		if (pick_stored(ra))
			send_item(crb_pkg::MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
				ra);
	endtask

	// All bytes of one chunk, with the odd read slipped in between.
	task automatic send_chunk(input int idx, input int tot, input int off, input int len);
		int n;
		n = (len == 0) ? 1 : len;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(19) == 0)
				read_back();
			send_item(crb_pkg::MODE_DATA, idx, tot, off, len, $urandom, $urandom);
		end
	endtask

	// A whole message: chunks in shuffled order, sometimes a repeat.
	task automatic send_message();
		int parts;
		int stride;
		int span;
		int lim;
		int base;
		int tot;
		int first_idx;
		int j;
		int tmp;
		int order [8];
		int lens [8];
		parts = $urandom_range(1, 8);
		stride = 24;
		span = parts * stride;
		lim = (cur_cap < crb_pkg::STORE_BYTES) ? cur_cap : crb_pkg::STORE_BYTES;
		if (lim > span && $urandom_range(3) != 0)
			base = $urandom_range(lim - span);
		else
			base = $urandom_range(crb_pkg::STORE_BYTES - span);
		tot = ($urandom_range(9) == 0) ? $urandom_range(127) : parts;
		first_idx = $urandom_range(crb_pkg::MAX_CHUNKS - parts);
		for (int k = 0; k < 8; k++) begin
			order[k] = k;
			lens[k] = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(6);
		end
		for (int k = parts - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		if ($urandom_range(9) < 7)
			send_item(crb_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		for (int k = 0; k < parts; k++) begin
			j = order[k];
			send_chunk(first_idx + j, tot, base + j * stride, lens[j]);
			if ($urandom_range(9) == 0)
				send_chunk(first_idx + j, tot, base + j * stride, lens[j]);
		end
		if ($urandom_range(1))
			repeat ($urandom_range(1, 3)) read_back();
	endtask

	// Mostly well-formed messages, the rest reads, clears and noise.
	task automatic random_burst();
		int pick;
		int idx;
		int off;
		pick = $urandom_range(99);
		idx = $urandom_range(crb_pkg::MAX_CHUNKS - 1);
		if (pick < 70) begin
			send_message();
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 4)) read_back();
		end else if (pick < 85) begin
			send_item(crb_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		end else if (pick < 90) begin
			send_item(crb_pkg::MODE_DATA, $urandom_range(crb_pkg::MAX_CHUNKS, 127), $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (pick < 93) begin
			send_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if ($urandom_range(1)) begin
			// Arbitrary geometry, then either a clear or a one-byte item ends the chunk.
			send_item(crb_pkg::MODE_DATA, idx, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			if ($urandom_range(1))
				send_item(crb_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			else
				send_item(crb_pkg::MODE_DATA, idx, $urandom, $urandom, 1, $urandom, $urandom);
		end else begin
			// The length shrinks part way through, cutting the chunk short.
			off = $urandom_range(4000);
			send_item(crb_pkg::MODE_DATA, idx, 4, off, 6, $urandom, $urandom);
			send_item(crb_pkg::MODE_DATA, idx, 4, off, 6, $urandom, $urandom);
			send_item(crb_pkg::MODE_DATA, idx, 4, off, 2, $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		int target;
		int waited;
		int cap_plan [9];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = crb_pkg::MODE_DATA;
		chunk_id     = '0;
		chunk_count  = '0;
		chunk_offset = '0;
		chunk_length = '0;
		data_byte    = '0;
		read_address = '0;
		cfg_valid    = 1'b0;
		cfg_data     = 13'd4096;
		cur_cap      = 4096;
		in_idle      = 20;
		out_idle     = 74;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset capacity.
		// Two-byte chunk at the very top of the store, first of two.
		send_item(crb_pkg::MODE_DATA, 0, 2, 4094, 2, 'hFF, 'hFFF);
		send_item(crb_pkg::MODE_DATA, 0, 2, 4094, 2, 'h00, 'h000);
		// Second chunk at address zero completes the message.
		send_item(crb_pkg::MODE_DATA, 1, 2, 0, 1, 'hA5, 'h000);
		// Duplicate of it must not overwrite the byte.
		send_item(crb_pkg::MODE_DATA, 1, 2, 0, 1, 'h5A, 'hFFF);
		// Zero-length chunk at the highest index, far beyond the store.
		send_item(crb_pkg::MODE_DATA, 63, 0, 'hFFFF, 0, 'h00, 'h000);
		// Indexes out of range are flagged and dropped.
		send_item(crb_pkg::MODE_DATA, 64, 64, 0, 1, 'h11, 'h000);
		send_item(crb_pkg::MODE_DATA, 127, 127, 'hFFFF, 'hFFFF, 'hFF, 'hFFF);
		send_item(MODE_UNUSED, 5, 5, 0, 0, 'h00, 'h000);
		send_item(crb_pkg::MODE_READ, 0, 0, 0, 0, 'h00, 4094);
		send_item(crb_pkg::MODE_READ, 0, 0, 0, 0, 'h00, 4095);
		send_item(crb_pkg::MODE_READ, 0, 0, 0, 0, 'h00, 0);
		// Largest possible end, then a one-byte item closes the chunk.
		send_item(crb_pkg::MODE_DATA, 5, 2, 'hFFFF, 'hFFFF, 'h33, 'h000);
		send_item(crb_pkg::MODE_DATA, 5, 2, 'hFFFF, 1, 'h44, 'h000);
		send_item(crb_pkg::MODE_CLEAR, 0, 0, 0, 0, 'h00, 'h000);
		// Largest chunk total after a clear.
		send_item(crb_pkg::MODE_DATA, 2, 127, 10, 0, 'h00, 'h000);
		send_item(crb_pkg::MODE_DATA, 3, 1, 20, 1, 'h77, 'h000);
		send_item(crb_pkg::MODE_CLEAR, 'h7F, 'h7F, 'hFFFF, 'hFFFF, 'hFF, 'hFFF);
		send_item(crb_pkg::MODE_DATA, 9, 1, 100, 3, 'h01, 'h000);
		send_item(crb_pkg::MODE_DATA, 9, 1, 100, 3, 'h02, 'h000);
		send_item(crb_pkg::MODE_DATA, 9, 1, 100, 3, 'h03, 'h000);
		send_item(crb_pkg::MODE_READ, 0, 0, 0, 0, 'h00, 101);

		// Random traffic under three handshake profiles and nine capacities.
		cap_plan = '{8191, 0, 4096, 4095, 64, 1, 2048, 0, 0};
		cap_plan[7] = $urandom_range(8191);
		cap_plan[8] = $urandom_range(100, 4096);
		for (int p = 0; p < 3; p++) begin
			in_idle  = (p == 0) ? 20 : (p == 1) ? 74 : 0;
			out_idle = (p == 0) ? 74 : (p == 1) ? 20 : 0;
			for (int s = 0; s < 3; s++) begin
				set_capacity(cap_plan[p * 3 + s]);
				target = items_sent + 80;
				while (items_sent < target)
					random_burst();
			end
		end

		// Drain and allow any stray result to show up.
		in_valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 20000);
		repeat (10) @(posedge clk);

		$display("Covered %0d data, %0d clear, %0d read and %0d unused-mode items;",
			n_data, n_clear, n_read, n_unused);
		$display("%0d results checked under three stall profiles and %0d capacity settings.",
			results_checked, cap_writes);
		if (fail_count == 0 && pending == 0)
			$display("chunk_reassembly_bitmap regression: pass");
		else
			$display("chunk_reassembly_bitmap regression: fail");
		$finish;
	end

endmodule

### sim.f
src/crb_pkg.sv
src/crb_store.sv
src/chunk_reassembly_bitmap.sv
src/crb_checker.sv
sim/chunk_reassembly_checker.sv
sim/chunk_reassembly_bitmap_test.sv
